/* rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the servo step positioner
// Field widths, angle limits, configuration register indexes and the
// classified command record that travels from the front to the back part.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int unsigned ANGLE_W    = 11;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned PULSE_W    = 15;
    localparam int unsigned DUTY_OUT_W = 12;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 11'd1800;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 11'd1200;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 15'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 15'd2500;
    localparam logic [ANGLE_W-1:0] BACKOFF_RESET   = 11'd50;

    // angle*span + min*1800 stays below 2^27
    localparam int unsigned SUM_W = 27;

    localparam int unsigned PERIOD_US_DEFAULT = 20000;
    localparam int unsigned DUTY_BITS_DEFAULT = 12;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF   = 2'd2;

    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_DOWN = 2'd1;
    localparam logic [OP_W-1:0] OP_UP   = 2'd2;

    typedef enum logic [1:0] {
        KIND_SET,
        KIND_DOWN,
        KIND_UP,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ANGLE_W-1:0] value;
        logic [ANGLE_W-1:0] target;
        logic               sw_before;
        logic               sw_after;
    } cmd_t;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W:0] a);
        logic [ANGLE_W-1:0] r;
        if (a > {1'b0, ANGLE_MAX})
            r = ANGLE_MAX;
        else
            r = a[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/ssp_if.sv */
// ----------------------------------------------------------------------------
// ssp_if: command and result channels of the servo step positioner
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssp_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ssp_pkg::OP_W-1:0]     operation;
    logic [ssp_pkg::ANGLE_W-1:0]  position_value;
    logic [ssp_pkg::ANGLE_W-1:0]  target_angle;
    logic                         switch_before;
    logic                         switch_after;

    modport source (
        output valid, operation, position_value, target_angle,
               switch_before, switch_after,
        input  ready
    );
    modport sink (
        input  valid, operation, position_value, target_angle,
               switch_before, switch_after,
        output ready
    );
endinterface

interface ssp_res_if;
    logic                            valid;
    logic                            ready;
    logic [ssp_pkg::DUTY_OUT_W-1:0]  pwm_duty;
    logic [ssp_pkg::ANGLE_W-1:0]     angle_now;
    logic                            done_res;

    modport source (
        output valid, pwm_duty, angle_now, done_res,
        input  ready
    );
    modport sink (
        input  valid, pwm_duty, angle_now, done_res,
        output ready
    );
endinterface

/* rtl/ssp_front.sv */
// ----------------------------------------------------------------------------
// ssp_front: command intake
// Accepts command items while the queue has room and classifies them:
// decodes the operation and clamps the set value and the step-up target.
// ----------------------------------------------------------------------------
module ssp_front (
    ssp_cmd_if.sink         cmd,
    input  logic            q_full,
    output logic            push,
    output ssp_pkg::cmd_t   entry
);

    always_comb
    begin
        entry.sw_before = cmd.switch_before;
        entry.sw_after  = cmd.switch_after;
        entry.target    = ssp_pkg::clamp_angle({1'b0, cmd.target_angle});
        entry.value     = cmd.position_value;
        case (cmd.operation)
            ssp_pkg::OP_SET:
            begin
                entry.kind  = ssp_pkg::KIND_SET;
                entry.value = ssp_pkg::clamp_angle({1'b0, cmd.position_value});
            end
            ssp_pkg::OP_DOWN: entry.kind = ssp_pkg::KIND_DOWN;
            ssp_pkg::OP_UP:   entry.kind = ssp_pkg::KIND_UP;
            default:          entry.kind = ssp_pkg::KIND_NOP;
        endcase
    end

    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full;

endmodule

/* rtl/ssp_queue.sv */
// ----------------------------------------------------------------------------
// ssp_queue: short command queue
// Small FIFO of classified commands between the front and the back part.
// ----------------------------------------------------------------------------
module ssp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ssp_pkg::cmd_t   entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ssp_pkg::cmd_t   head
);

    localparam int unsigned PTR_W = (ssp_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(ssp_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(ssp_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ssp_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ssp_pkg::QUEUE_DEPTH);

    ssp_pkg::cmd_t    slot_reg [ssp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= entry;
    end

endmodule

/* rtl/ssp_back.sv */
// ----------------------------------------------------------------------------
// ssp_back: angle update and duty computation
// Holds the angle and the configuration registers, applies one queued
// command, then scales the angle to a pulse width and divides it by the
// period: a reciprocal estimate of the quotient, one remainder step and at
// most two compare-and-subtract corrections give the PWM duty.
// ----------------------------------------------------------------------------
module ssp_back #(
    parameter int unsigned PERIOD_US = ssp_pkg::PERIOD_US_DEFAULT,
    parameter int unsigned DUTY_BITS = ssp_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              q_empty,
    input  ssp_pkg::cmd_t                     head,
    output logic                              pop,
    ssp_res_if.source                         res
);

    localparam int unsigned AW     = ssp_pkg::ANGLE_W;
    localparam int unsigned PW     = ssp_pkg::PULSE_W;
    localparam int unsigned QW     = ssp_pkg::DUTY_OUT_W;
    localparam int unsigned SUM_W  = ssp_pkg::SUM_W;
    localparam int unsigned NUM_W  = SUM_W + DUTY_BITS;
    localparam int unsigned DEN_INT = 1800 * PERIOD_US;
    localparam int unsigned DEN_W  = $clog2(DEN_INT + 1);
    localparam int unsigned WIDE_W = ((NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW) + 1;
    // estimate from the numerator bits above 2^EST_SH, which is not above the divisor 1800*PERIOD_US
    localparam int unsigned EST_SH   = DEN_W - 1;
    localparam int unsigned EST_IN_W = QW + 1;
    localparam int unsigned EST_T    = QW + 1;
    localparam int unsigned RECIP_W  = EST_T + 1;
    localparam int unsigned EST_P_W  = EST_IN_W + RECIP_W;
    localparam int unsigned PROD_W   = QW + DEN_W;
    localparam longint unsigned RECIP_INT = (64'd1 << (EST_SH + EST_T)) / 64'(DEN_INT);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_INT);
    localparam logic [DEN_W-1:0]   DEN_NARROW = DEN_W'(DEN_INT);
    localparam logic [WIDE_W-1:0]  DEN_VAL    = WIDE_W'(DEN_INT);
    localparam logic [WIDE_W-1:0]  DEN_TOP    = DEN_VAL << QW;
    localparam int unsigned SAT_INT = (DUTY_BITS >= QW) ? ((1 << QW) - 1)
                                                        : ((1 << DUTY_BITS) - 1);
    localparam logic [QW-1:0] SAT = QW'(SAT_INT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_CHECK,
        S_REM,
        S_FIX,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     min_reg, min_next;
    logic [PW-1:0]     max_reg, max_next;
    logic [AW-1:0]     backoff_reg, backoff_next;
    logic [AW-1:0]     angle_reg, angle_next;
    logic              done_reg, done_next;
    logic [PW-1:0]     span_reg, span_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic              valid_reg, valid_next;
    logic [QW-1:0]     duty_reg, duty_next;

    logic [AW-1:0]     cmd_angle;
    logic              cmd_done;
    logic [AW-1:0]     stepped;
    logic [AW:0]       up_sum;
    logic [NUM_W-1:0]  num;
    logic [EST_P_W-1:0] est_prod;
    logic [PROD_W-1:0] quo_den;

    // new angle and done flag for the command at the queue head
    always_comb
    begin
        cmd_angle = angle_reg;
        cmd_done  = 1'b0;
        stepped   = (head.value >= angle_reg) ? '0 : angle_reg - head.value;
        up_sum    = {1'b0, angle_reg} + {1'b0, head.value};
        case (head.kind)
            ssp_pkg::KIND_SET:
                cmd_angle = head.value;
            ssp_pkg::KIND_DOWN:
            begin
                cmd_done = 1'b1;
                if (head.sw_before)
                    cmd_angle = ssp_pkg::clamp_angle({1'b0, angle_reg} + {1'b0, backoff_reg});
                else if (angle_reg != '0)
                begin
                    if (head.sw_after)
                        cmd_angle = ssp_pkg::clamp_angle({1'b0, stepped} + {1'b0, backoff_reg});
                    else
                    begin
                        cmd_angle = stepped;
                        cmd_done  = (stepped == '0);
                    end
                end
            end
            ssp_pkg::KIND_UP:
            begin
                cmd_done = 1'b1;
                if (angle_reg < head.target)
                begin
                    if (up_sum >= {1'b0, head.target})
                        cmd_angle = head.target;
                    else
                    begin
                        cmd_angle = up_sum[AW-1:0];
                        cmd_done  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // full-scale factor 2^DUTY_BITS - 1 as shift and subtract
    assign num = (NUM_W'(sum_reg) << DUTY_BITS) - NUM_W'(sum_reg);

    // low by at most two when the quotient fits the duty width
    assign est_prod = EST_P_W'(rem_reg[EST_SH +: EST_IN_W]) * EST_P_W'(RECIP);
    assign quo_den  = PROD_W'(quo_reg) * PROD_W'(DEN_NARROW);

    always_comb
    begin
        state_next   = state_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        backoff_next = backoff_reg;
        angle_next   = angle_reg;
        done_next    = done_reg;
        span_next    = span_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ovf_next     = ovf_reg;
        valid_next   = valid_reg;
        duty_next    = duty_reg;
        pop          = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                ssp_pkg::CFG_MIN_PULSE: min_next     = cfg_data[PW-1:0];
                ssp_pkg::CFG_MAX_PULSE: max_next     = cfg_data[PW-1:0];
                ssp_pkg::CFG_BACKOFF:   backoff_next = cfg_data[AW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    angle_next = cmd_angle;
                    done_next  = cmd_done;
                    span_next  = (max_reg > min_reg) ? max_reg - min_reg : '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                sum_next   = SUM_W'(angle_reg) * SUM_W'(span_reg)
                           + SUM_W'(min_reg) * SUM_W'(ssp_pkg::ANGLE_MAX);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                rem_next   = WIDE_W'(num);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // quotient would not fit in the duty width: skip refinement
                ovf_next   = (rem_reg >= DEN_TOP);
                quo_next   = est_prod[EST_T +: QW];
                state_next = (rem_reg >= DEN_TOP) ? S_OUT : S_REM;
            end
            S_REM:
            begin
                rem_next   = rem_reg - WIDE_W'(quo_den);
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (rem_reg >= DEN_VAL)
                begin
                    rem_next = rem_reg - DEN_VAL;
                    quo_next = quo_reg + 1'b1;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!valid_reg)
                begin
                    valid_next = 1'b1;
                    duty_next  = (ovf_reg || quo_reg > SAT) ? SAT : quo_reg;
                end
                else if (res.ready)
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            min_reg     <= ssp_pkg::MIN_PULSE_RESET;
            max_reg     <= ssp_pkg::MAX_PULSE_RESET;
            backoff_reg <= ssp_pkg::BACKOFF_RESET;
            angle_reg   <= ssp_pkg::ANGLE_RESET;
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            span_reg    <= '0;
            sum_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            ovf_reg     <= 1'b0;
            duty_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            backoff_reg <= backoff_next;
            angle_reg   <= angle_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            span_reg    <= span_next;
            sum_reg     <= sum_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            ovf_reg     <= ovf_next;
            duty_reg    <= duty_next;
        end
    end

    assign res.valid     = valid_reg;
    assign res.pwm_duty  = duty_reg;
    assign res.angle_now = angle_reg;
    assign res.done_res  = done_reg;

endmodule

/* rtl/servo_step_positioner.sv */
// ----------------------------------------------------------------------------
// servo_step_positioner: servo angle stepper with PWM duty output
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    operation, position_value, target_angle,
//                                switch_before, switch_after
//   res      out  valid/ready    pwm_duty, angle_now, done_res
//   cfg      in   cfg_write      cfg_index, cfg_data (no read-back)
//
// After popping an item the back part goes through its steps up to
// res.valid: apply the command, multiply, scale, range check with quotient
// estimate, remainder, one to three correction steps, raise valid. A
// saturated duty skips remainder and corrections. The queue sits in
// front; the next item is popped the cycle after a result goes.
// Commands wait in a two-entry queue, so the front takes items while a
// result stalls on res.ready, until the queue is full. Reset restores the
// angle to 120 degrees and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module servo_step_positioner #(
    parameter int unsigned PERIOD_US = ssp_pkg::PERIOD_US_DEFAULT,
    parameter int unsigned DUTY_BITS = ssp_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ssp_cmd_if.sink                           cmd,
    ssp_res_if.source                         res,
    input  logic                              cfg_write,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    ssp_pkg::cmd_t entry;
    ssp_pkg::cmd_t head;

    ssp_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .push   (push),
        .entry  (entry)
    );

    ssp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (entry),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .head  (head)
    );

    ssp_back #(
        .PERIOD_US (PERIOD_US),
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .res       (res)
    );

endmodule

/* tb/servo_report_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_report_checker: predicts and checks servo step positioner results
// Watches the command, result and register write ports, keeps its own copy
// of the servo angle and pulse settings, computes the duty, angle and done
// flag for every accepted command and compares them with the results.
// ----------------------------------------------------------------------------
module servo_report_checker #(
    parameter int unsigned PERIOD_US = ssp_pkg::PERIOD_US_DEFAULT,
    parameter int unsigned DUTY_BITS = ssp_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ssp_cmd_if                             cmd,
    ssp_res_if                             res,
    input  logic                           cfg_write,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    localparam longint unsigned DUTY_FULL = (64'd1 << DUTY_BITS) - 64'd1;
    localparam longint unsigned DUTY_CAP  = 64'd4095;

    typedef logic [ssp_pkg::ANGLE_W-1:0] angle_t;
    typedef logic [ssp_pkg::PULSE_W-1:0] pulse_t;

    typedef struct packed {
        logic [ssp_pkg::DUTY_OUT_W-1:0] duty;
        angle_t                         angle;
        logic                           done;
    } servo_report_t;

    pulse_t min_us      = ssp_pkg::MIN_PULSE_RESET;
    pulse_t max_us      = ssp_pkg::MAX_PULSE_RESET;
    angle_t backoff     = ssp_pkg::BACKOFF_RESET;
    angle_t servo_angle = ssp_pkg::ANGLE_RESET;

    servo_report_t pending_reports[$];
    int            fail_total = 0;

    function automatic angle_t limit_angle(input logic [ssp_pkg::ANGLE_W:0] a);
        return (a > {1'b0, ssp_pkg::ANGLE_MAX}) ? ssp_pkg::ANGLE_MAX
                                                : a[ssp_pkg::ANGLE_W-1:0];
    endfunction

    function automatic logic [ssp_pkg::DUTY_OUT_W-1:0] duty_for(input angle_t a);
        longint unsigned span;
        longint unsigned num;
        longint unsigned quo;
        span = (max_us > min_us) ? longint'(max_us) - longint'(min_us) : 64'd0;
        num  = (longint'(a) * span + longint'(min_us) * 64'd1800) * DUTY_FULL;
        quo  = num / (64'd1800 * longint'(PERIOD_US));
        if (quo > DUTY_FULL)
            quo = DUTY_FULL;
        if (quo > DUTY_CAP)
            quo = DUTY_CAP;
        return quo[ssp_pkg::DUTY_OUT_W-1:0];
    endfunction

    // Apply one command to the angle and return the report it must cause.
    function automatic servo_report_t advance_servo(
        input logic [ssp_pkg::OP_W-1:0] op,
        input angle_t                   amount,
        input angle_t                   goal,
        input logic                     hit_before,
        input logic                     hit_after
    );
        angle_t                      ceiling;
        logic [ssp_pkg::ANGLE_W:0]   reach;
        servo_report_t               rep;
        rep.done = 1'b0;
        case (op)
            ssp_pkg::OP_SET:
                servo_angle = limit_angle({1'b0, amount});
            ssp_pkg::OP_DOWN:
            begin
                if (hit_before)
                begin
                    servo_angle = limit_angle({1'b0, servo_angle} + {1'b0, backoff});
                    rep.done    = 1'b1;
                end
                else if (servo_angle == '0)
                    rep.done = 1'b1;
                else
                begin
                    servo_angle = (amount >= servo_angle) ? '0 : servo_angle - amount;
                    if (hit_after)
                    begin
                        servo_angle = limit_angle({1'b0, servo_angle} + {1'b0, backoff});
                        rep.done    = 1'b1;
                    end
                    else
                        rep.done = (servo_angle == '0);
                end
            end
            ssp_pkg::OP_UP:
            begin
                ceiling = limit_angle({1'b0, goal});
                if (servo_angle >= ceiling)
                    rep.done = 1'b1;
                else
                begin
                    reach = {1'b0, servo_angle} + {1'b0, amount};
                    if (reach > {1'b0, ceiling})
                        reach = {1'b0, ceiling};
                    servo_angle = reach[ssp_pkg::ANGLE_W-1:0];
                    rep.done    = (servo_angle >= ceiling);
                end
            end
            default:
                ;
        endcase
        rep.angle = servo_angle;
        rep.duty  = duty_for(servo_angle);
        return rep;
    endfunction

    always @(posedge clk)
    begin
        servo_report_t want;
        if (!rst_n)
        begin
            min_us      = ssp_pkg::MIN_PULSE_RESET;
            max_us      = ssp_pkg::MAX_PULSE_RESET;
            backoff     = ssp_pkg::BACKOFF_RESET;
            servo_angle = ssp_pkg::ANGLE_RESET;
            pending_reports.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ssp_pkg::CFG_MIN_PULSE: min_us  = cfg_data[ssp_pkg::PULSE_W-1:0];
                    ssp_pkg::CFG_MAX_PULSE: max_us  = cfg_data[ssp_pkg::PULSE_W-1:0];
                    ssp_pkg::CFG_BACKOFF:   backoff = cfg_data[ssp_pkg::ANGLE_W-1:0];
                    default:                ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                pending_reports.push_back(advance_servo(cmd.operation, cmd.position_value,
                    cmd.target_angle, cmd.switch_before, cmd.switch_after));
            if (res.valid && res.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result with no item outstanding: pwm_duty %0d angle_now %0d done_res %0d",
                        res.pwm_duty, res.angle_now, res.done_res);
                    fail_total++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (res.pwm_duty !== want.duty)
                    begin
                        $error("pwm_duty: expected %0d, got %0d", want.duty, res.pwm_duty);
                        fail_total++;
                    end
                    if (res.angle_now !== want.angle)
                    begin
                        $error("angle_now: expected %0d, got %0d", want.angle, res.angle_now);
                        fail_total++;
                    end
                    if (res.done_res !== want.done)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done, res.done_res);
                        fail_total++;
                    end
                end
            end
        end
        outstanding <= pending_reports.size();
        mismatches  <= fail_total;
    end

endmodule

/* tb/tb_servo_step_positioner.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_step_positioner: stimulus and verdict for the servo positioner
// Drives directed corner commands, then phases of random commands and
// set/step sweeps under several pulse and backoff settings, with bursty
// sending, a stalling receiver and one long result hold-off. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_servo_step_positioner;

    typedef logic [ssp_pkg::ANGLE_W-1:0]    angle_t;
    typedef logic [ssp_pkg::PULSE_W-1:0]    pulse_t;
    typedef logic [ssp_pkg::OP_W-1:0]       op_t;
    typedef logic [ssp_pkg::CFG_DATA_W-1:0] cfg_word_t;

    localparam op_t OP_SPARE = 2'd3;

    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRESSURE_PHASE = 2;
    localparam int PAUSE_PHASE    = 4;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_write;
    logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index;
    cfg_word_t                      cfg_data;

    int mismatches;
    int outstanding;

    int items_sent    = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;
    bit offering      = 1'b0;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;

    ssp_cmd_if cmd_ch();
    ssp_res_if res_ch();

    servo_step_positioner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_report_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic withdraw_command();
        if (offering)
        begin
            cmd_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic offer_command(
        input op_t    op,
        input angle_t amount,
        input angle_t goal,
        input logic   hit_before,
        input logic   hit_after
    );
        int gap;
        cmd_ch.valid          <= 1'b1;
        cmd_ch.operation      <= op;
        cmd_ch.position_value <= amount;
        cmd_ch.target_angle   <= goal;
        cmd_ch.switch_before  <= hit_before;
        cmd_ch.switch_after   <= hit_after;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 11);
            gap = gaps_on ? $urandom_range(0, 40) : 0;
            if (gap > 0)
            begin
                withdraw_command();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold the sender until every result is back, then let the pipe empty.
    task automatic wait_for_results();
        withdraw_command();
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(
        input pulse_t lo_us,
        input pulse_t hi_us,
        input angle_t back
    );
        cfg_write <= 1'b1;
        cfg_index <= ssp_pkg::CFG_MIN_PULSE;
        cfg_data  <= lo_us;
        @(posedge clk);
        cfg_index <= ssp_pkg::CFG_MAX_PULSE;
        cfg_data  <= hi_us;
        @(posedge clk);
        cfg_index <= ssp_pkg::CFG_BACKOFF;
        cfg_data  <= cfg_word_t'(back);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_command();
        int     pick;
        op_t    op;
        angle_t amount;
        angle_t goal;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = ssp_pkg::OP_SET;
        else if (pick < 65)
            op = ssp_pkg::OP_DOWN;
        else if (pick < 95)
            op = ssp_pkg::OP_UP;
        else
            op = OP_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            amount = angle_t'($urandom_range(1801, 2047));
        else if (op == ssp_pkg::OP_SET || pick < 30)
            amount = angle_t'($urandom_range(0, 1800));
        else
            amount = angle_t'($urandom_range(0, 150));
        goal = ($urandom_range(0, 4) == 0) ? angle_t'($urandom_range(0, 2047))
                                           : angle_t'($urandom_range(0, 1800));
        offer_command(op, amount, goal, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 25);
    endtask

    // Set a start angle, climb toward a target, then walk back down.
    task automatic send_sweep();
        angle_t goal;
        angle_t stride;
        goal   = angle_t'($urandom_range(0, 1800));
        stride = angle_t'($urandom_range(1, 400));
        offer_command(ssp_pkg::OP_SET, angle_t'($urandom_range(0, 1800)),
            angle_t'($urandom_range(0, 2047)), 1'b0, 1'b0);
        repeat ($urandom_range(2, 6))
            offer_command(ssp_pkg::OP_UP, stride, goal, 1'b0, 1'b0);
        repeat ($urandom_range(2, 6))
            offer_command(ssp_pkg::OP_DOWN, stride, angle_t'($urandom_range(0, 2047)), 1'b0,
                $urandom_range(0, 7) == 0);
    endtask

    // Result receiver: random stall patterns, plus a long hold-off on request.
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       rx_tick;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        rx_tick   = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:   res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_ch.ready <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int     phase;
        int     phase_end;
        bit     paused;
        pulse_t lo_us;
        pulse_t hi_us;
        angle_t back;

        cmd_ch.valid          <= 1'b0;
        cmd_ch.operation      <= ssp_pkg::OP_SET;
        cmd_ch.position_value <= '0;
        cmd_ch.target_angle   <= '0;
        cmd_ch.switch_before  <= 1'b0;
        cmd_ch.switch_after   <= 1'b0;
        cfg_write             <= 1'b0;
        cfg_index             <= ssp_pkg::CFG_MIN_PULSE;
        cfg_data              <= '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed corners under the reset settings, starting from 120 degrees.
        offer_command(ssp_pkg::OP_UP,   11'd100,  11'd1000, 1'b0, 1'b0);
        offer_command(ssp_pkg::OP_SET,  11'd0,    11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_DOWN, 11'd10,   11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_DOWN, 11'd10,   11'd0,    1'b1, 1'b0);
        offer_command(ssp_pkg::OP_SET,  11'd2047, 11'd2047, 1'b1, 1'b1);
        offer_command(ssp_pkg::OP_DOWN, 11'd100,  11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_SET,  11'd1790, 11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_DOWN, 11'd5,    11'd0,    1'b1, 1'b1);
        offer_command(ssp_pkg::OP_DOWN, 11'd2047, 11'd2047, 1'b0, 1'b0);
        offer_command(ssp_pkg::OP_SET,  11'd30,   11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_DOWN, 11'd30,   11'd0,    1'b0, 1'b1);
        offer_command(ssp_pkg::OP_SET,  11'd1000, 11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_DOWN, 11'd100,  11'd0,    1'b0, 1'b1);
        offer_command(ssp_pkg::OP_UP,   11'd5,    11'd2047, 1'b0, 1'b0);
        offer_command(ssp_pkg::OP_SET,  11'd1800, 11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_UP,   11'd5,    11'd2047, 1'b1, 1'b1);
        offer_command(ssp_pkg::OP_SET,  11'd100,  11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_UP,   11'd50,   11'd500,  1'b0, 1'b0);
        offer_command(ssp_pkg::OP_UP,   11'd2047, 11'd500,  1'b0, 1'b0);
        offer_command(ssp_pkg::OP_UP,   11'd0,    11'd500,  1'b0, 1'b0);
        offer_command(ssp_pkg::OP_UP,   11'd0,    11'd1800, 1'b0, 1'b0);
        offer_command(OP_SPARE,         11'd2047, 11'd2047, 1'b1, 1'b1);
        offer_command(ssp_pkg::OP_SET,  11'd1801, 11'd0,    1'b0, 1'b0);
        offer_command(ssp_pkg::OP_DOWN, 11'd0,    11'd0,    1'b0, 1'b0);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    lo_us = 15'd0;     hi_us = 15'd20000; back = 11'd1800;
                end
                1:
                begin
                    lo_us = 15'd20000; hi_us = 15'd20000; back = 11'd0;
                end
                2:
                begin
                    lo_us = 15'd2500;  hi_us = 15'd500;   back = 11'd0;
                end
                4:
                begin
                    lo_us = 15'd0;     hi_us = 15'd0;     back = 11'd1;
                end
                5:
                begin
                    lo_us = 15'd20000; hi_us = 15'd0;     back = 11'd1800;
                end
                7:
                begin
                    lo_us = 15'd1000;  hi_us = 15'd2000;  back = 11'd100;
                end
                8:
                begin
                    lo_us = ssp_pkg::MIN_PULSE_RESET;
                    hi_us = ssp_pkg::MAX_PULSE_RESET;
                    back  = ssp_pkg::BACKOFF_RESET;
                end
                default:
                begin
                    lo_us = pulse_t'($urandom_range(0, 20000));
                    hi_us = pulse_t'($urandom_range(0, 20000));
                    back  = angle_t'($urandom_range(0, 1800));
                end
            endcase

            wait_for_results();
            apply_settings(lo_us, hi_us, back);

            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == PRESSURE_PHASE)
            begin
                // Keep offering while the receiver holds off, so the queue fills.
                gaps_on = 1'b0;
                hold_requests++;
            end

            paused    = 1'b0;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if (phase == PAUSE_PHASE && !paused && items_sent >= phase_end - PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    wait_for_results();
                end
                if ($urandom_range(0, 9) < 4)
                    send_sweep();
                else
                    send_random_command();
            end
        end

        wait_for_results();
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ssp_pkg.sv
rtl/ssp_if.sv
rtl/ssp_front.sv
rtl/ssp_queue.sv
rtl/ssp_back.sv
rtl/servo_step_positioner.sv
tb/servo_report_checker.sv
tb/tb_servo_step_positioner.sv
